// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the timestamp match queue.
// No dependencies; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/tsm_pkg.sv
// Shared types and constants of the timestamp match queue.
// No dependencies.
package tsm_pkg;

    localparam int TIME_W   = 48;
    localparam int LAT_W    = 31;
    localparam int LON_W    = 32;
    localparam int ALT_W    = 28;
    localparam int TOL_W    = 20;
    localparam int STALE_W  = 5;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 96;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam logic [TOL_W-1:0]   TOL_RESET = TOL_W'(10000);
    localparam logic [STALE_W-1:0] STALE_MAX = STALE_W'(31);

    typedef enum logic [STATUS_W-1:0] {
        STAT_QUEUED    = 2'd0,
        STAT_REFUSED   = 2'd1,
        STAT_MATCHED   = 2'd2,
        STAT_UNMATCHED = 2'd3
    } status_t;

    typedef struct packed {
        logic [ALT_W-1:0]  alt;
        logic [LON_W-1:0]  lon;
        logic [LAT_W-1:0]  lat;
        logic [TIME_W-1:0] fix_time;
    } fix_entry_t;

    typedef struct packed {
        logic [STALE_W-1:0] stale;
        logic [ALT_W-1:0]   alt;
        logic [LON_W-1:0]   lon;
        logic [LAT_W-1:0]   lat;
        status_t            status;
    } result_t;

endpackage

// File: rtl/tsm_store.sv
// Fix storage: one synchronous memory of queue entries, one write and one
// registered read port. Depends on tsm_pkg.
module tsm_store #(
    parameter int QUEUE_DEPTH = tsm_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int IDX_W       = $clog2(QUEUE_DEPTH)
) (
    input  logic                clk,
    input  logic                we,
    input  logic [IDX_W-1:0]    waddr,
    input  tsm_pkg::fix_entry_t wdata,
    input  logic [IDX_W-1:0]    raddr,
    output tsm_pkg::fix_entry_t rdata
);

    tsm_pkg::fix_entry_t mem [QUEUE_DEPTH];
    tsm_pkg::fix_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/tsm_ctrl.sv
// Queue sequencer: pushes fixes, scans from the head on a frame and builds
// the result item. Depends on tsm_pkg; drives the ports of tsm_store.
module tsm_ctrl #(
    parameter int QUEUE_DEPTH = tsm_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int IDX_W       = $clog2(QUEUE_DEPTH),
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_func,
    input  tsm_pkg::fix_entry_t        in_fix,
    input  logic [tsm_pkg::TOL_W-1:0]  tol,
    output logic                       res_valid,
    input  logic                       res_ready,
    output tsm_pkg::result_t           res,
    output logic                       mem_we,
    output logic [IDX_W-1:0]           mem_waddr,
    output tsm_pkg::fix_entry_t        mem_wdata,
    output logic [IDX_W-1:0]           mem_raddr,
    input  tsm_pkg::fix_entry_t        mem_rdata
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    state_t                           state_reg, state_next;
    logic [IDX_W-1:0]                 head_reg, head_next;
    logic [IDX_W-1:0]                 tail_reg, tail_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [tsm_pkg::STALE_W-1:0]      stale_reg, stale_next;
    logic [tsm_pkg::TIME_W-1:0]       frame_time_reg, frame_time_next;
    tsm_pkg::result_t                 res_reg, res_next;

    logic                             accept;
    logic                             full;
    logic                             newer_frame;
    logic [tsm_pkg::TIME_W-1:0]       diff;
    logic                             hit;
    logic [tsm_pkg::STALE_W-1:0]      stale_inc;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
        next_slot = (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign res_valid = (state_reg == ST_RESULT);
    assign res       = res_reg;

    // Only one item is in work at a time, so a push never meets a scan read.
    assign mem_we    = accept && !in_func && !full;
    assign mem_waddr = tail_reg;
    assign mem_wdata = in_fix;
    // Prefetch the entry after the head while scanning; used only on a pop.
    assign mem_raddr = (state_reg == ST_SCAN) ? next_slot(head_reg) : head_reg;

    assign newer_frame = (frame_time_reg >= mem_rdata.fix_time);
    assign diff        = newer_frame ? frame_time_reg - mem_rdata.fix_time
                                     : mem_rdata.fix_time - frame_time_reg;
    assign hit         = (diff <= {{(tsm_pkg::TIME_W - tsm_pkg::TOL_W){1'b0}}, tol});
    assign stale_inc   = (stale_reg == tsm_pkg::STALE_MAX) ? stale_reg
                                                           : stale_reg + tsm_pkg::STALE_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        stale_next      = stale_reg;
        frame_time_next = frame_time_reg;
        res_next        = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next        = '0;
                    stale_next      = '0;
                    frame_time_next = in_fix.fix_time;
                    state_next      = ST_RESULT;
                    if (!in_func)
                    begin
                        if (full)
                        begin
                            res_next.status = tsm_pkg::STAT_REFUSED;
                        end
                        else
                        begin
                            res_next.status = tsm_pkg::STAT_QUEUED;
                            tail_next       = next_slot(tail_reg);
                            count_next      = count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        res_next.status = tsm_pkg::STAT_UNMATCHED;
                        if (count_reg != '0)
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    head_next       = next_slot(head_reg);
                    count_next      = count_reg - CNT_W'(1);
                    res_next.status = tsm_pkg::STAT_MATCHED;
                    res_next.lat    = mem_rdata.lat;
                    res_next.lon    = mem_rdata.lon;
                    res_next.alt    = mem_rdata.alt;
                    res_next.stale  = stale_reg;
                    state_next      = ST_RESULT;
                end
                else if (newer_frame)
                begin
                    // Outdated fix: drop it and look at the next one.
                    head_next  = next_slot(head_reg);
                    count_next = count_reg - CNT_W'(1);
                    stale_next = stale_inc;
                    if (count_reg == CNT_W'(1))
                    begin
                        res_next.stale = stale_inc;
                        state_next     = ST_RESULT;
                    end
                end
                else
                begin
                    // Fix newer than the window: keep it queued.
                    res_next.stale = stale_reg;
                    state_next     = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stale_reg      <= stale_next;
        frame_time_reg <= frame_time_next;
        res_reg        <= res_next;
    end

endmodule

// File: rtl/timestamp_match_fifo.sv
// Top level of the timestamp match queue: stream ports, tolerance register,
// output register. Depends on tsm_pkg, tsm_ctrl, tsm_store, assert_macros.svh.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tuser func, s_tdata fix or frame
//  m_      | out | m_tvalid/m_tready  | m_tuser status, m_tdata match, stale
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_data match_tolerance
//
// A fix item is accepted with the memory write, then its result is offered.
// A frame item scans from the head, dropping outdated fixes until one matches,
// one lies in the future or the drops empty the queue: one head compare per
// cycle on the registered memory read, with the next entry prefetched.
// An empty queue goes straight to the result.
// The queue is empty after reset; the memory needs no clearing pass.
// A result waiting in the output register does not stop the next item from
// being accepted; only the one after that waits for m_tready.
`include "assert_macros.svh"

module timestamp_match_fifo #(
    parameter int QUEUE_DEPTH = tsm_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // event_time[47:0], fix_latitude[78:48], fix_longitude[110:79],
    // fix_altitude[138:111], zero fill[143:139]
    input  logic [tsm_pkg::S_TDATA_W-1:0]   s_tdata,
    // func[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // match_latitude[30:0], match_longitude[62:31], match_altitude[90:63],
    // stale_dropped[95:91]
    output logic [tsm_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[1:0]
    output logic [tsm_pkg::STATUS_W-1:0]    m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tsm_pkg::TOL_W-1:0]       cfg_data
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int FIX_W = tsm_pkg::TIME_W + tsm_pkg::LAT_W + tsm_pkg::LON_W
                           + tsm_pkg::ALT_W;
    localparam int STALE_LO = tsm_pkg::LAT_W + tsm_pkg::LON_W + tsm_pkg::ALT_W;

    logic [tsm_pkg::TOL_W-1:0]     tol_reg;
    logic                          m_tvalid_reg;
    logic [tsm_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [tsm_pkg::STATUS_W-1:0]  m_tuser_reg;

    tsm_pkg::fix_entry_t in_fix;
    tsm_pkg::result_t    res;
    logic                res_valid;
    logic                res_ready;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    tsm_pkg::fix_entry_t mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;
    tsm_pkg::fix_entry_t mem_rdata;

    logic [tsm_pkg::STALE_W-1:0]   out_stale;
    logic [STALE_LO-1:0]           out_coord;
    logic                          out_unmatched;

    // Field order of the entry struct matches the tdata layout.
    assign in_fix = tsm_pkg::fix_entry_t'(s_tdata[FIX_W-1:0]);

    assign res_ready = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    tsm_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser),
        .in_fix    (in_fix),
        .tol       (tol_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    tsm_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg      <= tsm_pkg::TOL_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                tol_reg <= cfg_data;
            end
            if (res_valid && res_ready)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_tdata_reg <= {res.stale, res.alt, res.lon, res.lat};
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign out_stale     = m_tdata_reg[tsm_pkg::M_TDATA_W-1:STALE_LO];
    assign out_coord     = m_tdata_reg[STALE_LO-1:0];
    assign out_unmatched = m_tvalid_reg && (m_tuser_reg == tsm_pkg::STAT_UNMATCHED);

    `ASSERT_CLK(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "ready after accept")
    `ASSERT_CLK(a_fix_no_stale, (m_tvalid && !m_tuser[1]) |-> (out_stale == '0), "stale on fix")
    `ASSERT_ALWAYS(a_unmatched_zero, out_unmatched |-> (out_coord == '0), "unmatched with data")

endmodule

// File: dv/timestamp_match_fifo_test.sv
// Testbench for timestamp_match_fifo: fixes and frame timestamps go in on the stream input,
// and each result is checked against a scoreboard that models the fix queue.
// Depends on tsm_pkg and the timestamp_match_fifo RTL.
`timescale 1ns / 1ps

module timestamp_match_fifo_test;
    import tsm_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 200;

    // Queue model plus the expected status and match of every accepted item.
    class match_scoreboard;
        logic [TOL_W-1:0] tolerance;
        fix_entry_t       fixes[$];
        result_t          expected[$];
        int               errors;

        function new();
            tolerance = TOL_RESET;
            errors = 0;
        endfunction

        function void note_input(logic is_frame, logic [TIME_W-1:0] t,
                                 logic [LAT_W-1:0] lat, logic [LON_W-1:0] lon,
                                 logic [ALT_W-1:0] alt);
            result_t           r;
            fix_entry_t        f;
            logic [TIME_W-1:0] diff;
            bit                scanning;
            r = '0;
            if (!is_frame)
            begin
                if (fixes.size() >= DEFAULT_QUEUE_DEPTH)
                begin
                    r.status = STAT_REFUSED;
                end
                else
                begin
                    f.fix_time = t;
                    f.lat = lat;
                    f.lon = lon;
                    f.alt = alt;
                    fixes.push_back(f);
                    r.status = STAT_QUEUED;
                end
            end
            else
            begin
                r.status = STAT_UNMATCHED;
                scanning = 1'b1;
                // Drop outdated fixes from the head, pop the first one in the window,
                // stop at a fix that is still in the future.
                while (scanning && fixes.size() > 0)
                begin
                    f = fixes[0];
                    diff = (t >= f.fix_time) ? t - f.fix_time : f.fix_time - t;
                    if (diff <= tolerance)
                    begin
                        r.status = STAT_MATCHED;
                        r.lat = f.lat;
                        r.lon = f.lon;
                        r.alt = f.alt;
                        void'(fixes.pop_front());
                        scanning = 1'b0;
                    end
                    else if (f.fix_time < t)
                    begin
                        void'(fixes.pop_front());
                        if (r.stale != STALE_MAX)
                            r.stale = r.stale + STALE_W'(1);
                    end
                    else
                    begin
                        scanning = 1'b0;
                    end
                end
            end
            expected.push_back(r);
        endfunction

        function void check_field(string name, logic [TIME_W-1:0] want,
                                  logic [TIME_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [M_TDATA_W-1:0] data);
            result_t want;
            if (expected.size() == 0)
            begin
                $display("%0t: result with no item pending, expected none, got %0d %0h",
                         $time, st, data);
                errors++;
            end
            else
            begin
                want = expected.pop_front();
                check_field("status", want.status, st);
                check_field("match_latitude", want.lat, data[30:0]);
                check_field("match_longitude", want.lon, data[62:31]);
                check_field("match_altitude", want.alt, data[90:63]);
                check_field("stale_dropped", want.stale, data[95:91]);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // event_time[47:0], fix_latitude[78:48], fix_longitude[110:79],
    // fix_altitude[138:111], zero fill[143:139]
    logic [S_TDATA_W-1:0]  s_tdata;
    // func[0]
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // match_latitude[30:0], match_longitude[62:31], match_altitude[90:63],
    // stale_dropped[95:91]
    logic [M_TDATA_W-1:0]  m_tdata;
    // status[1:0]
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [TOL_W-1:0]      cfg_data;

    match_scoreboard       sb;
    logic [TIME_W-1:0]     clock_us;
    int                    send_calm;
    int                    recv_calm;

    timestamp_match_fifo dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [TIME_W-1:0] rand_time();
        return {16'($urandom), $urandom};
    endfunction

    // Wait cycles before an item; now and then run a stretch with no waits at all.
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 13);
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic drive_item(input logic is_frame, input logic [TIME_W-1:0] t,
                              input logic [LAT_W-1:0] lat, input logic [LON_W-1:0] lon,
                              input logic [ALT_W-1:0] alt);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_frame;
        s_tdata  <= {5'b0, alt, lon, lat, t};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input(is_frame, t, lat, lon, alt);
        @(negedge clk);
    endtask

    task automatic send_fix(input logic [TIME_W-1:0] t);
        drive_item(1'b0, t, LAT_W'($urandom), $urandom, ALT_W'($urandom));
    endtask

    task automatic send_frame(input logic [TIME_W-1:0] t);
        drive_item(1'b1, t, LAT_W'($urandom), $urandom, ALT_W'($urandom));
    endtask

    // Hold the input idle until every result is back, then write the tolerance.
    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        s_tvalid <= 1'b0;
        while (sb.expected.size() != 0) @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.tolerance = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        int i;
        send_frame(48'd0);
        drive_item(1'b0, 48'd0, LAT_W'(900000000), LON_W'(1800000000), ALT_W'(100000000));
        send_frame(48'd10000);
        drive_item(1'b0, 48'd100, LAT_W'(-900000000), LON_W'(-1800000000), ALT_W'(-1000000));
        drive_item(1'b0, 48'd30000, {LAT_W{1'b1}}, {LON_W{1'b1}}, {ALT_W{1'b1}});
        send_frame(48'd20201);
        send_fix(48'd50000);
        send_frame(48'd39999);
        for (i = 1; i <= DEFAULT_QUEUE_DEPTH; i++)
            send_fix(48'd50000 + TIME_W'(i));
        send_frame({TIME_W{1'b1}});
    endtask

    task automatic run_phase(input int n_items);
        int                k;
        int                pick;
        int unsigned       tol;
        int unsigned       span;
        int unsigned       off;
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] t;
        k = 0;
        while (k < n_items)
        begin
            tol  = sb.tolerance;
            span = (tol < 8) ? 8 : tol;
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                // burst of fixes to run the queue full
                repeat ($urandom_range(10, 20))
                begin
                    clock_us = clock_us + TIME_W'($urandom_range(0, span / 2));
                    send_fix(clock_us);
                    k++;
                end
            end
            else if (pick < 52)
            begin
                if ($urandom_range(0, 32) == 0)
                    t = rand_time();
                else
                begin
                    clock_us = clock_us + TIME_W'($urandom_range(0, span / 2));
                    t = clock_us;
                end
                send_fix(t);
                k++;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60 && sb.fixes.size() > 0)
                begin
                    base = sb.fixes[$urandom_range(0, sb.fixes.size() - 1)].fix_time;
                    if (pick >= 45)
                        off = tol + 1;
                    else if ($urandom_range(0, 3) == 0)
                        off = tol;
                    else
                        off = $urandom_range(0, tol);
                    t = $urandom_range(0, 1) ? base + TIME_W'(off) : base - TIME_W'(off);
                end
                else if (pick < 60)
                    t = clock_us;
                else if (pick < 75)
                begin
                    // far ahead: flush the queue as outdated
                    clock_us = clock_us + TIME_W'(span) * 16;
                    t = clock_us;
                end
                else if (pick < 88)
                    t = clock_us - TIME_W'($urandom_range(0, span));
                else
                    t = rand_time();
                send_frame(t);
                k++;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [TOL_W-1:0] plan [6];
        int               p;
        sb = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        clock_us  = '0;
        send_calm = 0;
        plan[0] = '0;
        plan[1] = {TOL_W{1'b1}};
        plan[2] = TOL_W'(1000000);
        plan[3] = TOL_W'($urandom_range(1, 999999));
        plan[4] = TOL_W'(37);
        plan[5] = TOL_RESET;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        run_directed();
        for (p = 0; p < 6; p++)
        begin
            write_tolerance(plan[p]);
            run_phase(PHASE_ITEMS);
        end
        s_tvalid <= 1'b0;
        while (sb.expected.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.errors == 0)
            $display("timestamp_match_fifo verification clean");
        else
            $display("timestamp_match_fifo verification failed");
        $finish;
    end

    initial
    begin : result_sink
        int stall;
        int seen;
        seen = 0;
        recv_calm = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            // hold off twice for a long stretch so the queue and the input back up
            if (seen == 300 || seen == 900)
                stall = HOLD_CYCLES;
            else
                stall = draw_wait(recv_calm);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            sb.check_result(m_tuser, m_tdata);
            seen++;
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("timestamp_match_fifo verification failed");
        $finish;
    end

endmodule
